// ===== rtl/core/bscfn_pkg.sv =====
package bscfn_pkg;

    localparam int MAP_BITS  = 1024;
    localparam int WORD_BITS = 32;
    localparam int NUM_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_AW    = $clog2(WORD_BITS);
    localparam int IDX_W     = 11;
    localparam int FUNC_W    = 3;

    localparam logic [FUNC_W-1:0] FUNC_SET        = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR      = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_TEST_SET   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_TEST       = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_FIND_SET   = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_FIND_CLEAR = 3'd5;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [IDX_W-1:0]  bit_index;
        logic [IDX_W-1:0]  limit;
    } t_req;

    typedef struct packed {
        logic             bit_value;
        logic [IDX_W-1:0] found_index;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BIT_RD,
        ST_BIT_WR,
        ST_FIND,
        ST_OUT
    } t_state;

    // controls for the word scan unit
    typedef struct packed {
        logic              want;
        logic              lo_en;
        logic [BIT_AW-1:0] lo_bit;
        logic              hi_en;
        logic [BIT_AW-1:0] hi_bit;
    } t_scan_ctl;

    typedef struct packed {
        logic              hit;
        logic [BIT_AW-1:0] pos;
    } t_scan_res;

endpackage

// ===== rtl/core/bscfn_ram.sv =====
module bscfn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/bscfn_scan.sv =====
module bscfn_scan (
    input  logic [bscfn_pkg::WORD_BITS-1:0] i_word,
    input  bscfn_pkg::t_scan_ctl            i_ctl,
    output bscfn_pkg::t_scan_res            o_res
);

    localparam int W = bscfn_pkg::WORD_BITS;

    logic [W-1:0] want_bits;
    logic [W-1:0] lo_mask;
    logic [W-1:0] hi_mask;
    logic [W-1:0] cand;
    logic [bscfn_pkg::BIT_AW-1:0] hi_sh;

    always_comb begin
        want_bits = i_ctl.want ? i_word : ~i_word;
        lo_mask   = i_ctl.lo_en ? ({W{1'b1}} << i_ctl.lo_bit) : {W{1'b1}};
        // keep bits up to and including hi_bit
        hi_sh     = bscfn_pkg::BIT_AW'(W - 1) - i_ctl.hi_bit;
        hi_mask   = i_ctl.hi_en ? ({W{1'b1}} >> hi_sh) : {W{1'b1}};
        cand      = want_bits & lo_mask & hi_mask;
    end

    // lowest set candidate bit
    always_comb begin
        o_res.hit = |cand;
        o_res.pos = '0;
        for (int i = W - 1; i >= 0; i--) begin
            if (cand[i]) begin
                o_res.pos = bscfn_pkg::BIT_AW'(i);
            end
        end
    end

endmodule

// ===== rtl/core/bitmap_set_clear_find_next.sv =====
// Bitmap of 1024 bits, stored as 32 words of 32 bits in a RAM, all zero
// after reset.
// Request channel: i_valid / o_stall carrying i_item (func, bit_index,
// limit). Result channel: o_valid / i_stall carrying o_item (bit_value,
// found_index). Exactly one result per request.
// One request is worked on at a time; o_stall is high from acceptance
// until its result has been taken.
// Path from acceptance to o_valid:
//   set / clear / test-and-set / test inside the map: ST_BIT_RD (RAM read),
//     then ST_BIT_WR (read-modify-write of the word, no write for test), then ST_OUT.
//   find-next: ST_FIND, then ST_OUT; the word loop reads one RAM word per
//     cycle and checks it in the scan unit one word behind the read.
//   out-of-map bit ops, unused codes, start at or past limit: straight to ST_OUT.
// The result sits in an output register; while i_stall is high it holds
// and no new item is taken.
// Reset is synchronous (i_rst_n low) and clears the controller and the
// per-word valid flags, so the whole map reads as zero at once; no
// clearing pass is needed.
module bitmap_set_clear_find_next (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  bscfn_pkg::t_req i_item,
    output logic            o_valid,
    input  logic            i_stall,
    output bscfn_pkg::t_rsp o_item
);

    localparam int W     = bscfn_pkg::WORD_BITS;
    localparam int WA    = bscfn_pkg::WORD_AW;
    localparam int BA    = bscfn_pkg::BIT_AW;
    localparam int IW    = bscfn_pkg::IDX_W;
    localparam int NW    = bscfn_pkg::NUM_WORDS;

    bscfn_pkg::t_state r_state, n_state;

    logic [bscfn_pkg::FUNC_W-1:0] r_func, n_func;
    logic [IW-1:0]                r_idx, n_idx;
    logic [IW-1:0]                r_lim, n_lim;
    logic [WA-1:0]                r_last, n_last;
    logic [WA-1:0]                r_rd_word, n_rd_word;
    logic [WA-1:0]                r_chk_word, n_chk_word;
    logic                         r_chk_vld, n_chk_vld;
    logic                         r_bitv, n_bitv;
    logic [IW-1:0]                r_found, n_found;
    logic [NW-1:0]                r_wvalid, n_wvalid;

    logic          accept;
    logic [IW-1:0] lim_sat;
    logic [IW-1:0] lim_m1;
    logic          start_past;
    logic          in_map;
    logic          is_bit_op;
    logic          is_find;

    logic [WA-1:0] idx_word;
    logic [BA-1:0] idx_bit;
    logic [WA-1:0] cur_word;
    logic [W-1:0]  ram_q;
    logic [W-1:0]  word_data;
    logic [WA-1:0] ram_raddr;
    logic          ram_we;
    logic [W-1:0]  ram_wdata;
    logic          scan_done;

    bscfn_pkg::t_scan_ctl scan_ctl;
    bscfn_pkg::t_scan_res scan_res;

    function automatic logic [BA-1:0] lim_m1_r_bit(input logic [IW-1:0] lim);
        logic [IW-1:0] m1;
        m1 = lim - IW'(1);
        return m1[BA-1:0];
    endfunction

    assign accept  = i_valid && !o_stall;
    assign o_stall = (r_state != bscfn_pkg::ST_IDLE);
    assign o_valid = (r_state == bscfn_pkg::ST_OUT);
    assign o_item.bit_value   = r_bitv;
    assign o_item.found_index = r_found;

    // request decode at acceptance
    always_comb begin
        lim_sat    = (i_item.limit > IW'(bscfn_pkg::MAP_BITS)) ?
                     IW'(bscfn_pkg::MAP_BITS) : i_item.limit;
        lim_m1     = lim_sat - IW'(1);
        start_past = (i_item.bit_index >= lim_sat);
        in_map     = (i_item.bit_index < IW'(bscfn_pkg::MAP_BITS));
        is_bit_op  = (i_item.func == bscfn_pkg::FUNC_SET) ||
                     (i_item.func == bscfn_pkg::FUNC_CLEAR) ||
                     (i_item.func == bscfn_pkg::FUNC_TEST_SET) ||
                     (i_item.func == bscfn_pkg::FUNC_TEST);
        is_find    = (i_item.func == bscfn_pkg::FUNC_FIND_SET) ||
                     (i_item.func == bscfn_pkg::FUNC_FIND_CLEAR);
    end

    assign idx_word = r_idx[WA+BA-1:BA];
    assign idx_bit  = r_idx[BA-1:0];
    assign cur_word = (r_state == bscfn_pkg::ST_FIND) ? r_chk_word : idx_word;
    // a word never written reads as zero
    assign word_data = ram_q & {W{r_wvalid[cur_word]}};

    always_comb begin
        scan_ctl.want   = (r_func == bscfn_pkg::FUNC_FIND_SET);
        scan_ctl.lo_en  = (r_chk_word == idx_word);
        scan_ctl.lo_bit = idx_bit;
        scan_ctl.hi_en  = (r_chk_word == r_last);
        scan_ctl.hi_bit = lim_m1_r_bit(r_lim);
    end

    bscfn_scan u_scan (
        .i_word (word_data),
        .i_ctl  (scan_ctl),
        .o_res  (scan_res)
    );

    assign scan_done = r_chk_vld && (scan_res.hit || (r_chk_word == r_last));

    bscfn_ram #(
        .WIDTH (W),
        .DEPTH (NW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (idx_word),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bscfn_pkg::ST_IDLE: begin
                if (accept) begin
                    if (is_bit_op && in_map) begin
                        n_state = bscfn_pkg::ST_BIT_RD;
                    end else if (is_find && !start_past) begin
                        n_state = bscfn_pkg::ST_FIND;
                    end else begin
                        n_state = bscfn_pkg::ST_OUT;
                    end
                end
            end
            bscfn_pkg::ST_BIT_RD: n_state = bscfn_pkg::ST_BIT_WR;
            bscfn_pkg::ST_BIT_WR: n_state = bscfn_pkg::ST_OUT;
            bscfn_pkg::ST_FIND: begin
                if (scan_done) begin
                    n_state = bscfn_pkg::ST_OUT;
                end
            end
            bscfn_pkg::ST_OUT: begin
                if (!i_stall) begin
                    n_state = bscfn_pkg::ST_IDLE;
                end
            end
            default: n_state = bscfn_pkg::ST_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        n_func     = r_func;
        n_idx      = r_idx;
        n_lim      = r_lim;
        n_last     = r_last;
        n_rd_word  = r_rd_word;
        n_chk_word = r_chk_word;
        n_chk_vld  = r_chk_vld;
        n_bitv     = r_bitv;
        n_found    = r_found;
        n_wvalid   = r_wvalid;
        ram_raddr  = idx_word;
        ram_we     = 1'b0;
        ram_wdata  = word_data;
        unique case (r_state)
            bscfn_pkg::ST_IDLE: begin
                if (accept) begin
                    n_func     = i_item.func;
                    n_idx      = i_item.bit_index;
                    n_lim      = lim_sat;
                    n_last     = lim_m1[WA+BA-1:BA];
                    n_rd_word  = i_item.bit_index[WA+BA-1:BA];
                    n_chk_word = i_item.bit_index[WA+BA-1:BA];
                    n_chk_vld  = 1'b0;
                    n_bitv     = 1'b0;
                    n_found    = (is_find && start_past) ? lim_sat : '0;
                end
            end
            bscfn_pkg::ST_BIT_RD: begin
                ram_raddr = idx_word;
            end
            bscfn_pkg::ST_BIT_WR: begin
                n_bitv = word_data[idx_bit];
                case (r_func) inside
                    bscfn_pkg::FUNC_SET, bscfn_pkg::FUNC_TEST_SET: begin
                        ram_we    = 1'b1;
                        ram_wdata = word_data | (W'(1) << idx_bit);
                    end
                    bscfn_pkg::FUNC_CLEAR: begin
                        ram_we    = 1'b1;
                        ram_wdata = word_data & ~(W'(1) << idx_bit);
                    end
                    default: ram_we = 1'b0;
                endcase
                if (ram_we) begin
                    n_wvalid[idx_word] = 1'b1;
                end
            end
            bscfn_pkg::ST_FIND: begin
                // read one word ahead of the one being checked
                ram_raddr  = r_rd_word;
                n_rd_word  = r_rd_word + WA'(1);
                n_chk_word = r_rd_word;
                n_chk_vld  = 1'b1;
                if (r_chk_vld) begin
                    if (scan_res.hit) begin
                        n_found = IW'({r_chk_word, scan_res.pos});
                    end else begin
                        n_found = r_lim;
                    end
                end
            end
            bscfn_pkg::ST_OUT: begin
                ram_raddr = idx_word;
            end
            default: ram_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bscfn_pkg::ST_IDLE;
            r_chk_vld <= 1'b0;
            r_wvalid  <= '0;
        end else begin
            r_state   <= n_state;
            r_chk_vld <= n_chk_vld;
            r_wvalid  <= n_wvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_idx      <= n_idx;
        r_lim      <= n_lim;
        r_last     <= n_last;
        r_rd_word  <= n_rd_word;
        r_chk_word <= n_chk_word;
        r_bitv     <= n_bitv;
        r_found    <= n_found;
    end

endmodule

// ===== tb/bitmap_set_clear_find_next_tb.sv =====
`timescale 1ns / 100ps

module bitmap_set_clear_find_next_tb;

    localparam int CLK_PERIOD      = 8;
    localparam int RESET_CYCLES    = 8;
    localparam int ITEMS_PER_PHASE = 392;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int MAX_PRINTED     = 40;
    localparam int MAP_BITS        = bscfn_pkg::MAP_BITS;
    localparam int IDX_W           = bscfn_pkg::IDX_W;
    localparam int FUNC_W          = bscfn_pkg::FUNC_W;

    localparam logic [FUNC_W-1:0] F_SET        = bscfn_pkg::FUNC_SET;
    localparam logic [FUNC_W-1:0] F_CLEAR      = bscfn_pkg::FUNC_CLEAR;
    localparam logic [FUNC_W-1:0] F_TEST_SET   = bscfn_pkg::FUNC_TEST_SET;
    localparam logic [FUNC_W-1:0] F_TEST       = bscfn_pkg::FUNC_TEST;
    localparam logic [FUNC_W-1:0] F_FIND_SET   = bscfn_pkg::FUNC_FIND_SET;
    localparam logic [FUNC_W-1:0] F_FIND_CLEAR = bscfn_pkg::FUNC_FIND_CLEAR;

    // codes the block does not define; it must answer them with zeros
    localparam logic [FUNC_W-1:0] FUNC_RSVD_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_RSVD_7 = 3'd7;

    localparam logic [IDX_W-1:0] MAP_END  = IDX_W'(MAP_BITS);
    localparam logic [IDX_W-1:0] LAST_BIT = IDX_W'(MAP_BITS - 1);
    localparam logic [IDX_W-1:0] IDX_MAX  = '1;

    typedef struct {
        bscfn_pkg::t_req req;
        bit              typed;
        bscfn_pkg::t_rsp rsp;
    } t_directed_row;

    logic            i_clk = 1'b0;
    logic            i_rst_n;
    logic            i_valid;
    logic            o_stall;
    bscfn_pkg::t_req i_item;
    logic            o_valid;
    logic            i_stall;
    bscfn_pkg::t_rsp o_item;

    logic [MAP_BITS-1:0] shadow_map = '0;
    bscfn_pkg::t_rsp     pending_rsp[$];
    bscfn_pkg::t_rsp     head_rsp;
    int                  mismatches    = 0;
    int                  idle_phase    = 0;
    int                  send_idle_pct = 23;
    int                  recv_idle_pct = 46;
    bit                  hold_done     = 1'b0;

    bitmap_set_clear_find_next dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_item (i_item),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_item (o_item)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // applies one request to the shadow bitmap and returns its result
    function automatic bscfn_pkg::t_rsp apply_request(input bscfn_pkg::t_req r);
        bscfn_pkg::t_rsp rsp;
        int              lim;
        int              i;
        logic            want;
        rsp = '0;
        case (r.func) inside
            F_SET, F_CLEAR, F_TEST_SET, F_TEST: begin
                if (r.bit_index < MAP_BITS) begin
                    rsp.bit_value = shadow_map[r.bit_index];
                    if (r.func == F_SET || r.func == F_TEST_SET)
                        shadow_map[r.bit_index] = 1'b1;
                    else if (r.func == F_CLEAR)
                        shadow_map[r.bit_index] = 1'b0;
                end
            end
            F_FIND_SET, F_FIND_CLEAR: begin
                want = (r.func == F_FIND_SET);
                lim  = (r.limit > MAP_BITS) ? MAP_BITS : int'(r.limit);
                rsp.found_index = IDX_W'(lim);
                for (i = int'(r.bit_index); i < lim; i++) begin
                    if (shadow_map[i] == want) begin
                        rsp.found_index = IDX_W'(i);
                        break;
                    end
                end
            end
            default: ;
        endcase
        return rsp;
    endfunction

    function automatic t_directed_row plan_row(input logic [FUNC_W-1:0] f,
                                               input logic [IDX_W-1:0] idx,
                                               input logic [IDX_W-1:0] lim,
                                               input bit typed,
                                               input logic bv,
                                               input logic [IDX_W-1:0] found);
        t_directed_row row;
        row.req.func        = f;
        row.req.bit_index   = idx;
        row.req.limit       = lim;
        row.typed           = typed;
        row.rsp.bit_value   = bv;
        row.rsp.found_index = found;
        return row;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("%0t ns mismatch on %s: got %0d, want %0d", $time, field, got, want);
    endtask

    // offers one item, holds it until taken, then records what it should give
    task automatic send_request(input bscfn_pkg::t_req r, input bit typed,
                                input bscfn_pkg::t_rsp typed_rsp);
        bscfn_pkg::t_rsp predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= r;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        predicted = apply_request(r);
        pending_rsp.push_back(typed ? typed_rsp : predicted);
    endtask

    // result side: random stalls, plus one long hold-off when the second phase starts
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                i_stall <= 1'b0;
            end else if (idle_phase == 1 && !hold_done) begin
                hold_done = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_rsp.size() == 0) begin
                report_mismatch("unexpected result, found_index",
                                int'(o_item.found_index), 0);
            end else begin
                head_rsp = pending_rsp.pop_front();
                if (o_item.bit_value !== head_rsp.bit_value)
                    report_mismatch("bit_value", int'(o_item.bit_value),
                                    int'(head_rsp.bit_value));
                if (o_item.found_index !== head_rsp.found_index)
                    report_mismatch("found_index", int'(o_item.found_index),
                                    int'(head_rsp.found_index));
            end
        end
    end

    initial begin
        int stuck_cycles;
        stuck_cycles = 0;
        while (stuck_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("bitmap_set_clear_find_next regression: fail");
        $finish;
    end

    initial begin
        t_directed_row       plan[$];
        bscfn_pkg::t_req     req;
        int                  pick;
        int                  focus_base;
        int                  run_left;
        int                  run_idx;
        logic [FUNC_W-1:0]   run_func;

        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_item  <= '0;
        focus_base = 0;
        run_left   = 0;
        run_idx    = 0;
        run_func   = F_SET;

        // func, bit_index, limit, typed, bit_value, found_index
        plan.push_back(plan_row(F_TEST,       11'd0,    11'd0,    1, 1'b0, 11'd0));
        plan.push_back(plan_row(F_FIND_SET,   11'd0,    MAP_END,  1, 1'b0, MAP_END));
        plan.push_back(plan_row(F_FIND_CLEAR, 11'd0,    MAP_END,  1, 1'b0, 11'd0));
        plan.push_back(plan_row(F_SET,        11'd0,    11'd0,    1, 1'b0, 11'd0));
        plan.push_back(plan_row(F_SET,        LAST_BIT, 11'd0,    1, 1'b0, 11'd0));
        plan.push_back(plan_row(F_TEST_SET,   LAST_BIT, 11'd0,    1, 1'b1, 11'd0));
        plan.push_back(plan_row(F_TEST,       LAST_BIT, IDX_MAX,  1, 1'b1, 11'd0));
        // bit operations past the map do nothing
        plan.push_back(plan_row(F_SET,        MAP_END,  11'd0,    1, 1'b0, 11'd0));
        plan.push_back(plan_row(F_SET,        IDX_MAX,  IDX_MAX,  1, 1'b0, 11'd0));
        plan.push_back(plan_row(F_CLEAR,      IDX_MAX,  11'd0,    1, 1'b0, 11'd0));
        plan.push_back(plan_row(F_TEST_SET,   MAP_END,  11'd0,    1, 1'b0, 11'd0));
        // limit saturates to the map size
        plan.push_back(plan_row(F_FIND_SET,   11'd1,    IDX_MAX,  0, 1'b0, 11'd0));
        plan.push_back(plan_row(F_FIND_SET,   MAP_END,  IDX_MAX,  1, 1'b0, MAP_END));
        // start at or past the limit, then unused codes and clears of bit 0
        plan.push_back(plan_row(F_FIND_CLEAR, 11'd5,    11'd5,    1, 1'b0, 11'd5));
        plan.push_back(plan_row(F_FIND_CLEAR, 11'd9,    11'd3,    1, 1'b0, 11'd3));
        plan.push_back(plan_row(F_FIND_SET,   11'd0,    11'd0,    1, 1'b0, 11'd0));
        plan.push_back(plan_row(FUNC_RSVD_6,  11'd5,    11'd7,    1, 1'b0, 11'd0));
        plan.push_back(plan_row(FUNC_RSVD_7,  IDX_MAX,  IDX_MAX,  1, 1'b0, 11'd0));
        plan.push_back(plan_row(F_CLEAR,      11'd0,    11'd0,    1, 1'b1, 11'd0));
        plan.push_back(plan_row(F_CLEAR,      11'd0,    11'd0,    1, 1'b0, 11'd0));
        // word boundaries
        plan.push_back(plan_row(F_SET,        11'd31,   11'd0,    0, 1'b0, 11'd0));
        plan.push_back(plan_row(F_SET,        11'd32,   11'd0,    0, 1'b0, 11'd0));
        plan.push_back(plan_row(F_FIND_SET,   11'd0,    MAP_END,  0, 1'b0, 11'd0));
        plan.push_back(plan_row(F_FIND_CLEAR, 11'd31,   MAP_END,  0, 1'b0, 11'd0));
        plan.push_back(plan_row(F_FIND_SET,   11'd33,   LAST_BIT, 0, 1'b0, 11'd0));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k])
            send_request(plan[k].req, plan[k].typed, plan[k].rsp);

        for (int p = 0; p < 3; p++) begin
            idle_phase    = p;
            send_idle_pct = (p == 0) ? 23 : (p == 1) ? 46 : 0;
            recv_idle_pct = (p == 0) ? 46 : (p == 1) ? 23 : 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(99) < 2)
                    focus_base = $urandom_range(MAP_BITS - 64);
                // occasional runs of consecutive sets or clears build long
                // uniform stretches that the searches then have to cross
                if (run_left == 0 && $urandom_range(99) < 3) begin
                    run_left = $urandom_range(96, 16);
                    run_idx  = $urandom_range(MAP_BITS - 1);
                    run_func = ($urandom_range(3) == 0) ? F_CLEAR : F_SET;
                end
                if (run_left != 0) begin
                    req.func      = run_func;
                    req.bit_index = IDX_W'(run_idx);
                    req.limit     = IDX_W'($urandom);
                    run_idx++;
                    run_left--;
                end else begin
                    pick = $urandom_range(99);
                    if (pick < 25)      req.func = F_SET;
                    else if (pick < 40) req.func = F_CLEAR;
                    else if (pick < 50) req.func = F_TEST_SET;
                    else if (pick < 58) req.func = F_TEST;
                    else if (pick < 77) req.func = F_FIND_SET;
                    else if (pick < 96) req.func = F_FIND_CLEAR;
                    else if (pick < 98) req.func = FUNC_RSVD_6;
                    else                req.func = FUNC_RSVD_7;

                    pick = $urandom_range(99);
                    if (pick < 75) begin
                        req.bit_index = IDX_W'(focus_base + $urandom_range(63));
                    end else if (pick < 93) begin
                        req.bit_index = IDX_W'($urandom);
                    end else begin
                        case ($urandom_range(3))
                            0:       req.bit_index = '0;
                            1:       req.bit_index = LAST_BIT;
                            2:       req.bit_index = MAP_END;
                            default: req.bit_index = IDX_MAX;
                        endcase
                    end

                    pick = $urandom_range(99);
                    if (pick < 50)
                        req.limit = IDX_W'(req.bit_index + $urandom_range(80));
                    else if (pick < 80)
                        req.limit = IDX_W'($urandom_range(MAP_BITS));
                    else
                        req.limit = IDX_W'($urandom);
                end
                send_request(req, 1'b0, '0);
            end
        end
        i_valid <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("bitmap_set_clear_find_next regression: pass");
        else
            $display("bitmap_set_clear_find_next regression: fail");
        $finish;
    end

endmodule
